>>> sv/sbrf_pkg.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder package
// Sizes, the command and status codes, the operation codes and the word
// format that the front end hands to the search engine through the queue.
// ----------------------------------------------------------------------------
package sbrf_pkg;

  localparam int MAX_VERTS   = 64;
  localparam int ID_BITS     = 32;
  localparam int VID_W       = 32;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int OUT_IDX_W   = 6;
  localparam int IDX_W       = $clog2(MAX_VERTS);
  localparam int CNT_W       = $clog2(MAX_VERTS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR         = 2'd0,
    CMD_APPEND_PIECE  = 2'd1,
    CMD_APPEND_ORIGIN = 2'd2,
    CMD_COMPUTE       = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_NONE     = 2'd1,
    ST_WRAP     = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_WR_PIECE  = 2'd0,
    OP_WR_ORIGIN = 2'd1,
    OP_COMPUTE   = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [IDX_W-1:0]   addr;
    logic [ID_BITS-1:0] id;
    logic [CNT_W-1:0]   np;
    logic [CNT_W-1:0]   no;
    logic               ovf;
  } item_t;

endpackage

>>> sv/sbrf_front.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder front end
// Decodes each accepted word, keeps the list counts and the overflow flag,
// and turns computes and appends that fit into queue words for the engine.
// ----------------------------------------------------------------------------
module sbrf_front import sbrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [CMD_W-1:0] command_i,
  input  logic [VID_W-1:0] vertex_id_i,
  output logic             push_o,
  output item_t            item_o
);

  logic [CNT_W-1:0] pc_q, pc_d;
  logic [CNT_W-1:0] oc_q, oc_d;
  logic             ovf_q, ovf_d;

  always_comb begin
    pc_d        = pc_q;
    oc_d        = oc_q;
    ovf_d       = ovf_q;
    push_o      = 1'b0;
    item_o.op   = OP_COMPUTE;
    item_o.addr = '0;
    item_o.id   = ID_BITS'(vertex_id_i);
    item_o.np   = pc_q;
    item_o.no   = oc_q;
    item_o.ovf  = ovf_q;
    if (accept_i) begin
      case (cmd_e'(command_i))
        CMD_CLEAR: begin
          pc_d  = '0;
          oc_d  = '0;
          ovf_d = 1'b0;
        end
        CMD_APPEND_PIECE: begin
          if (pc_q < CNT_W'(MAX_VERTS)) begin
            push_o      = 1'b1;
            item_o.op   = OP_WR_PIECE;
            item_o.addr = pc_q[IDX_W-1:0];
            pc_d        = pc_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        CMD_APPEND_ORIGIN: begin
          if (oc_q < CNT_W'(MAX_VERTS)) begin
            push_o      = 1'b1;
            item_o.op   = OP_WR_ORIGIN;
            item_o.addr = oc_q[IDX_W-1:0];
            oc_d        = oc_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        CMD_COMPUTE: begin
          push_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= '0;
      oc_q  <= '0;
      ovf_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      oc_q  <= oc_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

>>> sv/sbrf_queue.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder queue
// A short first-in first-out buffer of words between the front end and the
// search engine.
// ----------------------------------------------------------------------------
module sbrf_queue import sbrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output item_t item_o,
  output logic  valid_o,
  output logic  full_o
);

  item_t             slots_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d;
  logic [QPTR_W-1:0] rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign item_o  = slots_q[rptr_q];
  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = wptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = rptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

>>> sv/sbrf_back.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder search engine
// Holds both vertex lists, writes appended vertices and runs the edge
// search and the run extension for compute words, each compare following
// its own read state.
// ----------------------------------------------------------------------------
module sbrf_back import sbrf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  input  item_t                q_item_i,
  output logic                 pop_o,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_IDX_W-1:0] first_piece_o,
  output logic [OUT_IDX_W-1:0] last_piece_o,
  output logic [OUT_IDX_W-1:0] first_origin_o,
  output logic [OUT_IDX_W-1:0] last_origin_o
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SRCH_RD  = 7'b0000010,
    S_SRCH_CMP = 7'b0000100,
    S_FWD_RD   = 7'b0001000,
    S_FWD_CMP  = 7'b0010000,
    S_BWD_RD   = 7'b0100000,
    S_BWD_CMP  = 7'b1000000
  } state_e;

  function automatic logic [IDX_W-1:0] ring_up(logic [IDX_W-1:0] k, logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] k1;
    k1 = CNT_W'(k) + CNT_W'(1);
    return (k1 >= n) ? '0 : k1[IDX_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] ring_down(logic [IDX_W-1:0] k, logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] n1;
    n1 = n - CNT_W'(1);
    return (k == '0) ? n1[IDX_W-1:0] : k - IDX_W'(1);
  endfunction

  logic [ID_BITS-1:0] piece_mem  [MAX_VERTS];
  logic [ID_BITS-1:0] origin_mem [MAX_VERTS];

  state_e           state_q, state_d;
  logic [CNT_W-1:0] np_q, np_d, no_q, no_d;
  logic [IDX_W-1:0] ci_q, ci_d, cj_q, cj_d;
  logic [IDX_W-1:0] mi_q, mi_d, mj_q, mj_d;
  logic [IDX_W-1:0] fp_q, fp_d, lp_q, lp_d, fo_q, fo_d, lo_q, lo_d;
  status_e          status_q, status_d;
  logic             valid_q, valid_d;

  logic [ID_BITS-1:0] p0_q, p1_q, o0_q, o1_q;
  logic [IDX_W-1:0]   pa0, pa1, oa0, oa1;
  logic [IDX_W-1:0]   ci_up, ci_dn, cj_up, cj_dn;
  logic               wr_piece, wr_origin;
  logic               fin;
  status_e            fin_st;

  assign ci_up = ring_up(ci_q, np_q);
  assign ci_dn = ring_down(ci_q, np_q);
  assign cj_up = ring_up(cj_q, no_q);
  assign cj_dn = ring_down(cj_q, no_q);

  assign pa0 = (state_q == S_BWD_RD) ? ci_dn : ci_q;
  assign oa0 = (state_q == S_BWD_RD) ? cj_up : cj_q;
  assign pa1 = ci_up;
  assign oa1 = cj_dn;

  always_comb begin
    state_d   = state_q;
    np_d      = np_q;
    no_d      = no_q;
    ci_d      = ci_q;
    cj_d      = cj_q;
    mi_d      = mi_q;
    mj_d      = mj_q;
    fp_d      = fp_q;
    lp_d      = lp_q;
    fo_d      = fo_q;
    lo_d      = lo_q;
    status_d  = status_q;
    valid_d   = 1'b0;
    pop_o     = 1'b0;
    wr_piece  = 1'b0;
    wr_origin = 1'b0;
    fin       = 1'b0;
    fin_st    = ST_FOUND;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          pop_o = 1'b1;
          case (q_item_i.op)
            OP_WR_PIECE: begin
              wr_piece = 1'b1;
            end
            OP_WR_ORIGIN: begin
              wr_origin = 1'b1;
            end
            OP_COMPUTE: begin
              np_d = q_item_i.np;
              no_d = q_item_i.no;
              if (q_item_i.ovf) begin
                fin    = 1'b1;
                fin_st = ST_OVERFLOW;
              end else if (q_item_i.np == '0 || q_item_i.no == '0) begin
                fin    = 1'b1;
                fin_st = ST_NONE;
              end else begin
                ci_d    = '0;
                cj_d    = IDX_W'(q_item_i.no - CNT_W'(1));
                state_d = S_SRCH_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRCH_RD: begin
        state_d = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (p0_q == o0_q && p1_q == o1_q) begin
          mi_d    = ci_q;
          mj_d    = cj_q;
          state_d = S_FWD_RD;
        end else if (cj_q == '0) begin
          if (CNT_W'(ci_q) + CNT_W'(1) >= np_q) begin
            fin     = 1'b1;
            fin_st  = ST_NONE;
            state_d = S_IDLE;
          end else begin
            ci_d    = ci_q + IDX_W'(1);
            cj_d    = IDX_W'(no_q - CNT_W'(1));
            state_d = S_SRCH_RD;
          end
        end else begin
          cj_d    = cj_q - IDX_W'(1);
          state_d = S_SRCH_RD;
        end
      end
      S_FWD_RD: begin
        state_d = S_FWD_CMP;
      end
      S_FWD_CMP: begin
        if (p1_q == o1_q) begin
          if (ci_up == mi_q || cj_dn == mj_q) begin
            fin     = 1'b1;
            fin_st  = ST_WRAP;
            state_d = S_IDLE;
          end else begin
            ci_d    = ci_up;
            cj_d    = cj_dn;
            state_d = S_FWD_RD;
          end
        end else begin
          lp_d    = ci_q;
          fo_d    = cj_q;
          ci_d    = mi_q;
          cj_d    = mj_q;
          state_d = S_BWD_RD;
        end
      end
      S_BWD_RD: begin
        state_d = S_BWD_CMP;
      end
      S_BWD_CMP: begin
        if (p0_q == o0_q) begin
          if (ci_dn == mi_q || cj_up == mj_q) begin
            fin     = 1'b1;
            fin_st  = ST_WRAP;
            state_d = S_IDLE;
          end else begin
            ci_d    = ci_dn;
            cj_d    = cj_up;
            state_d = S_BWD_RD;
          end
        end else begin
          fp_d    = ci_q;
          lo_d    = cj_q;
          fin     = 1'b1;
          fin_st  = ST_FOUND;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (fin) begin
      valid_d  = 1'b1;
      status_d = fin_st;
      if (fin_st != ST_FOUND) begin
        fp_d = '0;
        lp_d = '0;
        fo_d = '0;
        lo_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_piece) begin
      piece_mem[q_item_i.addr] <= q_item_i.id;
    end
    if (wr_origin) begin
      origin_mem[q_item_i.addr] <= q_item_i.id;
    end
    p0_q <= piece_mem[pa0];
    p1_q <= piece_mem[pa1];
    o0_q <= origin_mem[oa0];
    o1_q <= origin_mem[oa1];
  end

  always_ff @(posedge clk_i) begin
    np_q     <= np_d;
    no_q     <= no_d;
    ci_q     <= ci_d;
    cj_q     <= cj_d;
    mi_q     <= mi_d;
    mj_q     <= mj_d;
    fp_q     <= fp_d;
    lp_q     <= lp_d;
    fo_q     <= fo_d;
    lo_q     <= lo_d;
    status_q <= status_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign valid_o        = valid_q;
  assign status_o       = status_q;
  assign first_piece_o  = OUT_IDX_W'(fp_q);
  assign last_piece_o   = OUT_IDX_W'(lp_q);
  assign first_origin_o = OUT_IDX_W'(fo_q);
  assign last_origin_o  = OUT_IDX_W'(lo_q);

endmodule

>>> sv/shared_boundary_run_finder.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder
// A word is taken when start is high and busy is low; busy is high only while
// the four-entry queue in front of the search engine is full. Clear words stay
// in the front end and each append that fits is written by the engine. Once
// popped, a compute gives its result on valid_o from the idle state for an
// overflow or an empty list, else after the search over the compared pairs
// (at most np * no) and the extension steps. The receiver cannot stall.
// After reset both lists are empty, the overflow flag is clear and the queue
// is empty.
// ----------------------------------------------------------------------------
module shared_boundary_run_finder import sbrf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [CMD_W-1:0]     command_i,
  input  logic [VID_W-1:0]     vertex_id_i,
  output logic                 valid_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [OUT_IDX_W-1:0] first_piece_o,
  output logic [OUT_IDX_W-1:0] last_piece_o,
  output logic [OUT_IDX_W-1:0] first_origin_o,
  output logic [OUT_IDX_W-1:0] last_origin_o
);

  logic  accept;
  logic  push;
  item_t push_item;
  logic  pop;
  item_t head_item;
  logic  head_valid;
  logic  full;

  assign accept = start && !busy;
  assign busy   = full;

  sbrf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .command_i   (command_i),
    .vertex_id_i (vertex_id_i),
    .push_o      (push),
    .item_o      (push_item)
  );

  sbrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .item_o  (head_item),
    .valid_o (head_valid),
    .full_o  (full)
  );

  sbrf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (head_valid),
    .q_item_i       (head_item),
    .pop_o          (pop),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .first_piece_o  (first_piece_o),
    .last_piece_o   (last_piece_o),
    .first_origin_o (first_origin_o),
    .last_origin_o  (last_origin_o)
  );

endmodule

>>> tb/shared_boundary_run_finder_tb.sv
// ----------------------------------------------------------------------------
// Shared boundary run finder testbench
// Loads piece and origin vertex loops, issues compute words and checks every
// reported run against the table or a predictor with its own copy of both
// lists. A table of directed words covers the empty, single-vertex, wrap
// and overflow cases. Random loops with planted reversed runs, colliding ids
// and loose command mixes follow. The sender idles in random bursts.
// ----------------------------------------------------------------------------
module shared_boundary_run_finder_tb import sbrf_pkg::*; ();

  localparam int TIMEOUT_CYCLES = 20000000;
  localparam int RANDOM_WORDS   = 300;
  localparam int RANDOM_RUNS    = 12;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [OUT_IDX_W-1:0] first_piece;
    logic [OUT_IDX_W-1:0] last_piece;
    logic [OUT_IDX_W-1:0] first_origin;
    logic [OUT_IDX_W-1:0] last_origin;
  } run_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [VID_W-1:0] vid;
    logic [7:0]       reps;
    logic             typed;
    run_t             want;
  } step_row_t;

  localparam run_t RUN_NONE = '{ST_NONE, 6'd0, 6'd0, 6'd0, 6'd0};
  localparam run_t RUN_WRAP = '{ST_WRAP, 6'd0, 6'd0, 6'd0, 6'd0};
  localparam run_t RUN_OVF  = '{ST_OVERFLOW, 6'd0, 6'd0, 6'd0, 6'd0};

  localparam int DIR_ROWS = 28;
  localparam step_row_t DIRECTED [DIR_ROWS] = '{
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_NONE},
    '{CMD_APPEND_PIECE,  32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_NONE},
    '{CMD_APPEND_ORIGIN, 32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_COMPUTE,       32'hFFFF_FFFF, 8'd1, 1'b1, RUN_WRAP},
    '{CMD_CLEAR,         32'hFFFF_FFFF, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'hFFFF_FFFF, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'h1234_5678, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'hAAAA_AAAA, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'h5555_5555, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'h1234_5678, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'hFFFF_FFFF, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'h0000_0007, 8'd1, 1'b0, '0},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_CLEAR,         32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'h0000_0001, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'h0000_0002, 8'd1, 1'b0, '0},
    '{CMD_APPEND_PIECE,  32'h0000_0003, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'h0000_0003, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'h0000_0002, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'h0000_0001, 8'd1, 1'b0, '0},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_WRAP},
    '{CMD_CLEAR,         32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_APPEND_ORIGIN, 32'hDEAD_BEEF, 8'(MAX_VERTS + 1), 1'b0, '0},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_OVF},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_OVF},
    '{CMD_CLEAR,         32'h0000_0000, 8'd1, 1'b0, '0},
    '{CMD_COMPUTE,       32'h0000_0000, 8'd1, 1'b1, RUN_NONE}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [CMD_W-1:0]     command_i = '0;
  logic [VID_W-1:0]     vertex_id_i = '0;
  logic                 valid_o;
  logic [STATUS_W-1:0]  status_o;
  logic [OUT_IDX_W-1:0] first_piece_o;
  logic [OUT_IDX_W-1:0] last_piece_o;
  logic [OUT_IDX_W-1:0] first_origin_o;
  logic [OUT_IDX_W-1:0] last_origin_o;

  logic [VID_W-1:0] piece_vid  [MAX_VERTS];
  logic [VID_W-1:0] origin_vid [MAX_VERTS];
  int               piece_len = 0;
  int               origin_len = 0;
  bit               lists_overflowed = 1'b0;

  logic [VID_W-1:0] gen_piece  [MAX_VERTS];
  logic [VID_W-1:0] gen_origin [MAX_VERTS];

  run_t pending_runs [$];
  int   mismatches = 0;
  int   cycle_count = 0;
  int   words_sent = 0;
  int   runs_sent = 0;
  int   burst_left = 0;
  bit   gaps_on = 1'b1;

  shared_boundary_run_finder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .vertex_id_i    (vertex_id_i),
    .valid_o        (valid_o),
    .status_o       (status_o),
    .first_piece_o  (first_piece_o),
    .last_piece_o   (last_piece_o),
    .first_origin_o (first_origin_o),
    .last_origin_o  (last_origin_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic int wrap_inc(input int k, input int n);
    return (k + 1 >= n) ? 0 : k + 1;
  endfunction

  function automatic int wrap_dec(input int k, input int n);
    return (k == 0) ? n - 1 : k - 1;
  endfunction

  function automatic run_t find_shared_run();
    run_t run;
    int   mi, mj, i, j, ni, nj, lp, fo;
    bit   hit;
    run = RUN_NONE;
    if (lists_overflowed) begin
      return RUN_OVF;
    end
    if (piece_len == 0 || origin_len == 0) begin
      return run;
    end
    hit = 1'b0;
    mi = 0;
    mj = 0;
    for (i = 0; i < piece_len && !hit; i++) begin
      for (j = origin_len - 1; j >= 0 && !hit; j--) begin
        if (piece_vid[i] == origin_vid[j] &&
            piece_vid[wrap_inc(i, piece_len)] == origin_vid[wrap_dec(j, origin_len)]) begin
          mi = i;
          mj = j;
          hit = 1'b1;
        end
      end
    end
    if (!hit) begin
      return run;
    end
    i = mi;
    j = mj;
    ni = wrap_inc(i, piece_len);
    nj = wrap_dec(j, origin_len);
    while (piece_vid[ni] == origin_vid[nj]) begin
      if (ni == mi || nj == mj) begin
        return RUN_WRAP;
      end
      i = ni;
      j = nj;
      ni = wrap_inc(i, piece_len);
      nj = wrap_dec(j, origin_len);
    end
    lp = i;
    fo = j;
    i = mi;
    j = mj;
    ni = wrap_dec(i, piece_len);
    nj = wrap_inc(j, origin_len);
    while (piece_vid[ni] == origin_vid[nj]) begin
      if (ni == mi || nj == mj) begin
        return RUN_WRAP;
      end
      i = ni;
      j = nj;
      ni = wrap_dec(i, piece_len);
      nj = wrap_inc(j, origin_len);
    end
    run.status       = ST_FOUND;
    run.first_piece  = OUT_IDX_W'(i);
    run.last_piece   = OUT_IDX_W'(lp);
    run.first_origin = OUT_IDX_W'(fo);
    run.last_origin  = OUT_IDX_W'(j);
    return run;
  endfunction

  function automatic bit apply_word(input cmd_e cmd, input logic [VID_W-1:0] vid,
                                    output run_t run);
    run = '0;
    case (cmd)
      CMD_CLEAR: begin
        piece_len = 0;
        origin_len = 0;
        lists_overflowed = 1'b0;
      end
      CMD_APPEND_PIECE: begin
        if (piece_len < MAX_VERTS) begin
          piece_vid[piece_len] = vid;
          piece_len++;
        end else begin
          lists_overflowed = 1'b1;
        end
      end
      CMD_APPEND_ORIGIN: begin
        if (origin_len < MAX_VERTS) begin
          origin_vid[origin_len] = vid;
          origin_len++;
        end else begin
          lists_overflowed = 1'b1;
        end
      end
      default: begin
        run = find_shared_run();
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [VID_W-1:0] pick_id(input bit pooled);
    if (!pooled) begin
      return $urandom();
    end
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0001;
      default: return 32'h7FFF_FFFE;
    endcase
  endfunction

  task automatic send_word(input cmd_e cmd, input logic [VID_W-1:0] vid,
                           input bit typed = 1'b0, input run_t want = '0);
    run_t run;
    if (burst_left == 0) begin
      if (gaps_on) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start       <= 1'b1;
    command_i   <= cmd;
    vertex_id_i <= vid;
    do @(posedge clk_i); while (busy);
    words_sent++;
    if (apply_word(cmd, vid, run)) begin
      pending_runs.push_back(typed ? want : run);
      runs_sent++;
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_runs.size() != 0);
    burst_left = 0;
  endtask

  task automatic send_lists(input int np, input int no);
    bit origin_first;
    int k;
    origin_first = ($urandom_range(0, 4) == 0);
    if (origin_first) begin
      for (k = 0; k < no; k++) send_word(CMD_APPEND_ORIGIN, gen_origin[k]);
    end
    for (k = 0; k < np; k++) send_word(CMD_APPEND_PIECE, gen_piece[k]);
    if (!origin_first) begin
      for (k = 0; k < no; k++) send_word(CMD_APPEND_ORIGIN, gen_origin[k]);
    end
  endtask

  task automatic random_loop_pair();
    int kind, np, no, run, s, pre, post, k;
    bit pooled;
    kind = $urandom_range(0, 99);
    pooled = ($urandom_range(0, 3) == 0);
    if (kind < 55) begin
      np = ($urandom_range(0, 19) == 0) ? MAX_VERTS : $urandom_range(1, 12);
      for (k = 0; k < np; k++) gen_piece[k] = pick_id(pooled);
      no = 0;
      if (np == 1) begin
        pre = $urandom_range(0, 4);
        for (k = 0; k < pre; k++) begin
          gen_origin[no] = pick_id(pooled);
          no++;
        end
        gen_origin[no] = gen_piece[0];
        no++;
      end else begin
        run = ($urandom_range(0, 6) == 0) ? np - 1 : $urandom_range(1, np - 1);
        s = $urandom_range(0, np - 1);
        pre = (run == np - 1) ? 0 : $urandom_range(0, 3);
        post = (run == np - 1) ? 0 : $urandom_range(0, 3);
        if (run + 1 + pre + post > MAX_VERTS) begin
          pre = 0;
          post = 0;
        end
        for (k = 0; k < pre; k++) begin
          gen_origin[no] = pick_id(pooled);
          no++;
        end
        for (k = run; k >= 0; k--) begin
          gen_origin[no] = gen_piece[(s + k) % np];
          no++;
        end
        for (k = 0; k < post; k++) begin
          gen_origin[no] = pick_id(pooled);
          no++;
        end
      end
      if ($urandom_range(0, 9) != 0) send_word(CMD_CLEAR, $urandom());
      send_lists(np, no);
      send_word(CMD_COMPUTE, $urandom());
    end else if (kind < 72) begin
      np = $urandom_range(1, 8);
      no = $urandom_range(1, 8);
      for (k = 0; k < np; k++) gen_piece[k] = pick_id(1'b1);
      for (k = 0; k < no; k++) gen_origin[k] = pick_id(1'b1);
      send_word(CMD_CLEAR, $urandom());
      send_lists(np, no);
      send_word(CMD_COMPUTE, $urandom());
    end else if (kind < 78) begin
      send_word(CMD_CLEAR, $urandom());
      np = MAX_VERTS + $urandom_range(1, 3);
      for (k = 0; k < np; k++) begin
        send_word(($urandom_range(0, 1) == 0) ? CMD_APPEND_PIECE : CMD_APPEND_ORIGIN,
                  pick_id(pooled));
      end
      send_word(CMD_COMPUTE, $urandom());
      if ($urandom_range(0, 1) == 0) send_word(CMD_COMPUTE, $urandom());
    end else begin
      np = $urandom_range(4, 16);
      for (k = 0; k < np; k++) begin
        send_word(cmd_e'($urandom_range(0, 3)), pick_id($urandom_range(0, 1) == 0));
      end
      send_word(CMD_COMPUTE, $urandom());
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("shared_boundary_run_finder_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    run_t want;
    run_t got;
    if (rst_ni && valid_o) begin
      got = '{status_o, first_piece_o, last_piece_o, first_origin_o, last_origin_o};
      if (pending_runs.size() == 0) begin
        $display("%0t: unexpected run word st=%0d fp=%0d lp=%0d fo=%0d lo=%0d", $time,
                 got.status, got.first_piece, got.last_piece, got.first_origin,
                 got.last_origin);
        mismatches++;
      end else begin
        want = pending_runs.pop_front();
        if (got !== want) begin
          $display("%0t: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                   $time, want.status, want.first_piece, want.last_piece,
                   want.first_origin, want.last_origin, got.status, got.first_piece,
                   got.last_piece, got.first_origin, got.last_origin);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int r = 0; r < DIR_ROWS; r++) begin
      repeat (DIRECTED[r].reps) begin
        send_word(DIRECTED[r].cmd, DIRECTED[r].vid, DIRECTED[r].typed, DIRECTED[r].want);
      end
    end
    wait_drain();
    words_sent = 0;
    runs_sent = 0;
    while (words_sent < RANDOM_WORDS || runs_sent < RANDOM_RUNS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      random_loop_pair();
      if ($urandom_range(0, 9) == 0) wait_drain();
    end
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("shared_boundary_run_finder_tb OK");
    end else begin
      $display("shared_boundary_run_finder_tb NOT OK");
    end
    $finish;
  end

endmodule
